/* design/gtpr_pkg.sv */
// Shared constants, command codes and the built-in 5x7 font for the text renderer.
package gtpr_pkg;

   localparam int GLYPH_COLS = 5;
   localparam int GLYPH_ROWS = 7;
   localparam int ADVANCE    = 6;

   localparam logic [6:0] COLON_BITS = 7'h36;
   localparam logic [6:0] DASH_BITS  = 7'h08;

   typedef enum logic [1:0] {
      CMD_DRAW  = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   localparam logic [6:0] FONT_DIGITS [0:9][0:GLYPH_COLS-1] = '{
      '{7'h3e, 7'h51, 7'h49, 7'h45, 7'h3e}, '{7'h00, 7'h42, 7'h7f, 7'h40, 7'h00},
      '{7'h42, 7'h61, 7'h51, 7'h49, 7'h46}, '{7'h21, 7'h41, 7'h45, 7'h4b, 7'h31},
      '{7'h18, 7'h14, 7'h12, 7'h7f, 7'h10}, '{7'h27, 7'h45, 7'h45, 7'h45, 7'h39},
      '{7'h3c, 7'h4a, 7'h49, 7'h49, 7'h30}, '{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
      '{7'h36, 7'h49, 7'h49, 7'h49, 7'h36}, '{7'h06, 7'h49, 7'h49, 7'h29, 7'h1e}
   };

   localparam logic [6:0] FONT_UPPER [0:25][0:GLYPH_COLS-1] = '{
      '{7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e}, '{7'h7f, 7'h49, 7'h49, 7'h49, 7'h36},
      '{7'h3e, 7'h41, 7'h41, 7'h41, 7'h22}, '{7'h7f, 7'h41, 7'h41, 7'h22, 7'h1c},
      '{7'h7f, 7'h49, 7'h49, 7'h49, 7'h41}, '{7'h7f, 7'h09, 7'h09, 7'h09, 7'h01},
      '{7'h3e, 7'h41, 7'h49, 7'h49, 7'h7a}, '{7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f},
      '{7'h00, 7'h41, 7'h7f, 7'h41, 7'h00}, '{7'h20, 7'h40, 7'h41, 7'h3f, 7'h01},
      '{7'h7f, 7'h08, 7'h14, 7'h22, 7'h41}, '{7'h7f, 7'h40, 7'h40, 7'h40, 7'h40},
      '{7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f}, '{7'h7f, 7'h04, 7'h08, 7'h10, 7'h7f},
      '{7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e}, '{7'h7f, 7'h09, 7'h09, 7'h09, 7'h06},
      '{7'h3e, 7'h41, 7'h51, 7'h21, 7'h5e}, '{7'h7f, 7'h09, 7'h19, 7'h29, 7'h46},
      '{7'h46, 7'h49, 7'h49, 7'h49, 7'h31}, '{7'h01, 7'h01, 7'h7f, 7'h01, 7'h01},
      '{7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f}, '{7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f},
      '{7'h7f, 7'h20, 7'h18, 7'h20, 7'h7f}, '{7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
      '{7'h03, 7'h04, 7'h78, 7'h04, 7'h03}, '{7'h61, 7'h51, 7'h49, 7'h45, 7'h43}
   };

   function automatic logic [6:0] glyph_column(input logic [7:0] code, input logic [2:0] col);
      logic [6:0] bits;
      logic [3:0] digit;
      logic [4:0] letter;
      bits   = '0;
      digit  = 4'(code - 8'h30);
      letter = 5'(code - 8'h41);
      if (int'(col) < GLYPH_COLS) begin
         if (code inside {[8'h30:8'h39]}) begin
            bits = FONT_DIGITS[digit][col];
         end else if (code inside {[8'h41:8'h5a]}) begin
            bits = FONT_UPPER[letter][col];
         end else if (code == 8'h3a) begin
            bits = (col == 3'd1 || col == 3'd2) ? COLON_BITS : 7'h00;
         end else if (code == 8'h2d) begin
            bits = DASH_BITS;
         end
      end
      return bits;
   endfunction

endpackage

/* design/gtpr_if.sv */
// Valid/ready channel interfaces for the request and response sides of the renderer.
interface gtpr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] char_code;
   logic       start_text;
   logic [7:0] pos_x;
   logic [7:0] pos_y;
   logic [6:0] read_column;
   logic [1:0] read_page;

   modport source (output valid, cmd, char_code, start_text, pos_x, pos_y, read_column,
                   read_page, input ready);
   modport sink   (input valid, cmd, char_code, start_text, pos_x, pos_y, read_column,
                   read_page, output ready);
endinterface

interface gtpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;

   modport source (output valid, read_data, input ready);
   modport sink   (input valid, read_data, output ready);
endinterface

/* design/glyph_text_page_renderer.sv */
// Top level of the text renderer: control sequencer and page-organised frame store.
//
// A draw transfer is accepted in the idle state and then takes ten read-modify-write steps
// through the frame store, which has one read and one write port (five glyph columns, each
// touching up to two pages, with the read of one step overlapping the write-back of the
// previous one), and a drain state that retires the last write. A draw that is dropped at
// the right edge or carries a null character leaves the sequencer idle. A read transfer
// fetches its byte, then loads the response register once any earlier response is taken,
// and that register lets further transfers be accepted while it waits. A clear sweeps the
// store at one byte per cycle; the same sweep runs after reset, when no request is accepted.
module glyph_text_page_renderer
   import gtpr_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 32
) (
   input  logic       clock,
   input  logic       reset,
   gtpr_req_if.sink   req_if,
   gtpr_rsp_if.source rsp_if
);

   localparam int PAGE_TOTAL  = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_TOTAL;
   localparam int AW          = $clog2(STORE_BYTES);
   localparam int LAST_ROWS   = SCREEN_HEIGHT - 8 * (PAGE_TOTAL - 1);
   localparam logic [7:0] LAST_MASK = 8'((1 << LAST_ROWS) - 1);
   localparam int COL_LIMIT   = SCREEN_WIDTH - 5;
   localparam int STEP_COUNT  = 2 * GLYPH_COLS;
   localparam int SW          = $clog2(STEP_COUNT);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DRAW,
      ST_DRAIN,
      ST_READ
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] clear_ff, clear_in;
   logic [7:0]    cursor_col_ff, cursor_col_in;
   logic [7:0]    cursor_row_ff, cursor_row_in;
   logic [7:0]    base_col_ff, base_col_in;
   logic [7:0]    base_row_ff, base_row_in;
   logic [7:0]    code_ff, code_in;
   logic [SW-1:0] step_ff, step_in;
   logic          wr_pend_ff, wr_pend_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic [7:0]    wr_mask_ff, wr_mask_in;
   logic          read_zero_ff, read_zero_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;

   logic [7:0]    frame_mem [0:STORE_BYTES-1];
   logic [7:0]    rdata_ff;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [7:0]    mem_wr_data;

   logic          req_fire;
   logic [7:0]    col_sel;
   logic [7:0]    row_sel;
   logic [2:0]    step_col;
   logic [6:0]    glyph_bits;
   logic [14:0]   shifted;
   logic [4:0]    page_lo;
   logic [4:0]    page_hi;
   logic [4:0]    step_page;
   logic          step_page_ok;
   logic [7:0]    step_bits;
   logic [7:0]    step_column;
   logic [AW-1:0] step_addr;
   logic [AW-1:0] read_addr;
   logic          read_in_range;

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign req_fire         = req_if.valid && req_if.ready;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.read_data = rsp_data_ff;

   assign col_sel = req_if.start_text ? req_if.pos_x : cursor_col_ff;
   assign row_sel = req_if.start_text ? req_if.pos_y : cursor_row_ff;

   assign step_col     = 3'(step_ff >> 1);
   assign glyph_bits   = glyph_column(code_ff, step_col);
   assign shifted      = {8'h00, glyph_bits} << base_row_ff[2:0];
   assign page_lo      = base_row_ff[7:3];
   assign page_hi      = page_lo + 5'd1;
   assign step_page    = step_ff[0] ? page_hi : page_lo;
   assign step_page_ok = int'(step_page) < PAGE_TOTAL;
   assign step_bits    = (step_ff[0] ? {1'b0, shifted[14:8]} : shifted[7:0])
                         & ((int'(step_page) == PAGE_TOTAL - 1) ? LAST_MASK : 8'hff);
   assign step_column  = base_col_ff + {5'd0, step_col};
   assign step_addr    = AW'(int'(step_column) + int'(step_page) * SCREEN_WIDTH);

   assign read_in_range = int'(req_if.read_column) < SCREEN_WIDTH
                          && int'(req_if.read_page) < PAGE_TOTAL;
   assign read_addr     = AW'(int'(req_if.read_column) + int'(req_if.read_page) * SCREEN_WIDTH);

   always_comb begin
      state_in      = state_ff;
      clear_in      = clear_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      base_col_in   = base_col_ff;
      base_row_in   = base_row_ff;
      code_in       = code_ff;
      step_in       = step_ff;
      wr_pend_in    = 1'b0;
      wr_addr_in    = wr_addr_ff;
      wr_mask_in    = wr_mask_ff;
      read_zero_in  = read_zero_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in   = rsp_data_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = read_addr;
      mem_wr_en     = wr_pend_ff;
      mem_wr_addr   = wr_addr_ff;
      mem_wr_data   = rdata_ff | wr_mask_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clear_ff;
            mem_wr_data = '0;
            if (int'(clear_ff) == STORE_BYTES - 1) begin
               state_in = ST_IDLE;
            end else begin
               clear_in = clear_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_if.cmd)
                  CMD_DRAW: begin
                     cursor_col_in = col_sel;
                     cursor_row_in = row_sel;
                     if (req_if.char_code != 8'h00 && int'(col_sel) <= COL_LIMIT) begin
                        base_col_in   = col_sel;
                        base_row_in   = row_sel;
                        code_in       = req_if.char_code;
                        step_in       = '0;
                        cursor_col_in = col_sel + 8'(ADVANCE);
                        state_in      = ST_DRAW;
                     end
                  end
                  CMD_CLEAR: begin
                     clear_in = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_READ: begin
                     mem_rd_en    = read_in_range;
                     read_zero_in = !read_in_range;
                     state_in     = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DRAW: begin
            mem_rd_en   = step_page_ok;
            mem_rd_addr = step_addr;
            wr_pend_in  = step_page_ok && (step_bits != 8'h00);
            wr_addr_in  = step_addr;
            wr_mask_in  = step_bits;
            if (int'(step_ff) == STEP_COUNT - 1) begin
               state_in = ST_DRAIN;
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         ST_READ: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = read_zero_ff ? 8'h00 : rdata_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_ff      <= '0;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         step_ff       <= '0;
         wr_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_ff      <= clear_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         step_ff       <= step_in;
         wr_pend_ff    <= wr_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         base_col_ff   <= base_col_in;
         base_row_ff   <= base_row_in;
         code_ff       <= code_in;
         wr_addr_ff    <= wr_addr_in;
         wr_mask_ff    <= wr_mask_in;
         read_zero_ff  <= read_zero_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         frame_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rdata_ff <= frame_mem[mem_rd_addr];
      end
   end

   // A pending write-back must retire before the sequencer can accept another transfer.
   assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> (state_ff == ST_DRAW || state_ff == ST_DRAIN))
      else $error("write-back pending outside a draw");

   // A response is only ever raised on completion of a read transfer.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_READ))
      else $error("response raised without a read");

   // The step counter stays within the glyph while drawing.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAW) |-> (int'(step_ff) < STEP_COUNT))
      else $error("draw step out of range");

   // A character is only drawn when its cell fits inside the right edge.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAW) |-> (int'(base_col_ff) <= COL_LIMIT))
      else $error("draw started beyond the right edge");

endmodule
